[hdl/olte_pkg.sv]
// Shared types, codes and sizes for the ordered list table engine.
package olte_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int FPOS_W  = 6;
    localparam int ECNT_W  = 7;
    localparam int ENTRY_W = 2 * VAL_W;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
    localparam logic [OP_W-1:0] OP_READ      = 3'd3;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic        [OP_W-1:0]  operation;
        logic        [POS_W-1:0] position;
        logic signed [VAL_W-1:0] value_real;
        logic signed [VAL_W-1:0] value_imag;
    } t_item;

    typedef struct packed {
        logic        [ST_W-1:0]   status;
        logic signed [VAL_W-1:0]  read_real;
        logic signed [VAL_W-1:0]  read_imag;
        logic        [FPOS_W-1:0] found_position;
        logic        [ECNT_W-1:0] entry_count;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic            load;
        logic            rd_en;
        logic            wr_en;
        logic            wr_from_ram;
        logic            idx_inc;
        logic            idx_dec;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            done;
        logic [ST_W-1:0] status;
        logic            res_read;
        logic            res_found;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_gt_count;
        logic            pos_ge_count;
        logic            full;
        logic            idx_gt_pos;
        logic            idx_next_lt_count;
        logic            idx_lt_count;
        logic            match;
    } t_dp_status;

endpackage

[hdl/olte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module olte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/olte_ctrl.sv]
// Controller state machine: sequences checks, shifts, scans and results.
module olte_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  olte_pkg::t_dp_status i_status,
    output olte_pkg::t_cmd     o_cmd,
    output logic               o_busy
);
    import olte_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_STEP_RD = 3'd2;
    localparam logic [2:0] S_STEP_WR = 3'd3;
    localparam logic [2:0] S_READ    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_status.op)
                    OP_APPEND: begin
                        n_state  = S_IDLE;
                        cmd.done = 1'b1;
                        if (i_status.full) begin
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.wr_en   = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    OP_INSERT: begin
                        if (i_status.pos_gt_count) begin
                            cmd.done   = 1'b1;
                            cmd.status = ST_RANGE;
                            n_state    = S_IDLE;
                        end else if (i_status.full) begin
                            cmd.done   = 1'b1;
                            cmd.status = ST_FULL;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_STEP_RD;
                        end
                    end
                    OP_DELETE: begin
                        if (i_status.pos_ge_count) begin
                            cmd.done   = 1'b1;
                            cmd.status = ST_RANGE;
                            n_state    = S_IDLE;
                        end else begin
                            n_state = S_STEP_RD;
                        end
                    end
                    OP_READ: begin
                        if (i_status.pos_ge_count) begin
                            cmd.done   = 1'b1;
                            cmd.status = ST_RANGE;
                            n_state    = S_IDLE;
                        end else begin
                            cmd.rd_en = 1'b1;
                            n_state   = S_READ;
                        end
                    end
                    OP_OVERWRITE: begin
                        cmd.done = 1'b1;
                        n_state  = S_IDLE;
                        if (i_status.pos_ge_count) begin
                            cmd.status = ST_RANGE;
                        end else begin
                            cmd.wr_en = 1'b1;
                        end
                    end
                    OP_FIND: begin
                        n_state = S_STEP_RD;
                    end
                    default: begin
                        cmd.done = 1'b1;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_STEP_RD: begin
                case (i_status.op)
                    OP_INSERT: begin
                        if (i_status.idx_gt_pos) begin
                            cmd.rd_en = 1'b1;
                            n_state   = S_STEP_WR;
                        end else begin
                            // gap is open: drop the new value in
                            cmd.wr_en   = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            cmd.done    = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    OP_DELETE: begin
                        if (i_status.idx_next_lt_count) begin
                            cmd.rd_en = 1'b1;
                            n_state   = S_STEP_WR;
                        end else begin
                            cmd.cnt_dec = 1'b1;
                            cmd.done    = 1'b1;
                            n_state     = S_IDLE;
                        end
                    end
                    default: begin
                        if (i_status.idx_lt_count) begin
                            cmd.rd_en = 1'b1;
                            n_state   = S_STEP_WR;
                        end else begin
                            cmd.done   = 1'b1;
                            cmd.status = ST_NOTFOUND;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            S_STEP_WR: begin
                case (i_status.op)
                    OP_INSERT: begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_from_ram = 1'b1;
                        cmd.idx_dec     = 1'b1;
                        n_state         = S_STEP_RD;
                    end
                    OP_DELETE: begin
                        cmd.wr_en       = 1'b1;
                        cmd.wr_from_ram = 1'b1;
                        cmd.idx_inc     = 1'b1;
                        n_state         = S_STEP_RD;
                    end
                    default: begin
                        if (i_status.match) begin
                            cmd.done      = 1'b1;
                            cmd.res_found = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            n_state     = S_STEP_RD;
                        end
                    end
                endcase
            end
            S_READ: begin
                cmd.done     = 1'b1;
                cmd.res_read = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

[hdl/olte_dp.sv]
// Datapath: request registers, entry count, walking index, entry memory, result.
module olte_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  olte_pkg::t_item      i_item,
    input  olte_pkg::t_cmd       i_cmd,
    output olte_pkg::t_dp_status o_status,
    output logic                 o_done,
    output olte_pkg::t_result    o_result
);
    import olte_pkg::*;

    logic [OP_W-1:0]    r_op;
    logic [POS_W-1:0]   r_pos;
    logic [ENTRY_W-1:0] r_val;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   n_idx;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_done;
    t_result            r_result;
    t_result            n_result;

    logic [CNT_W-1:0]   rd_idx;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;

    // index the walk starts from
    always_comb begin
        case (i_item.operation)
            OP_APPEND: n_idx = r_count;
            OP_INSERT: n_idx = r_count;
            OP_FIND:   n_idx = '0;
            default:   n_idx = CNT_W'(i_item.position);
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_item.operation;
            r_pos <= i_item.position;
            r_val <= {i_item.value_real, i_item.value_imag};
            r_idx <= n_idx;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.done) begin
            r_result <= n_result;
        end
    end

    // insert pulls from below, delete pulls from above
    always_comb begin
        case (r_op)
            OP_INSERT: rd_idx = r_idx - 1'b1;
            OP_DELETE: rd_idx = r_idx + 1'b1;
            default:   rd_idx = r_idx;
        endcase
    end

    assign wr_data = i_cmd.wr_from_ram ? rd_data : r_val;

    olte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_idx[IDX_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_result                = '0;
        n_result.status         = i_cmd.status;
        n_result.entry_count    = ECNT_W'(n_count);
        if (i_cmd.res_read) begin
            n_result.read_real = rd_data[ENTRY_W-1:VAL_W];
            n_result.read_imag = rd_data[VAL_W-1:0];
        end
        if (i_cmd.res_found) begin
            n_result.found_position = FPOS_W'(r_idx);
        end
    end

    assign o_status.op                = r_op;
    assign o_status.pos_gt_count      = CMP_W'(r_pos) > CMP_W'(r_count);
    assign o_status.pos_ge_count      = CMP_W'(r_pos) >= CMP_W'(r_count);
    assign o_status.full              = (r_count == CNT_W'(DEPTH));
    assign o_status.idx_gt_pos        = CMP_W'(r_idx) > CMP_W'(r_pos);
    assign o_status.idx_next_lt_count =
        ((CNT_W + 1)'(r_idx) + 1'b1) < (CNT_W + 1)'(r_count);
    assign o_status.idx_lt_count      = (r_idx < r_count);
    assign o_status.match             = (rd_data == r_val);

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[hdl/ordered_list_table_engine.sv]
// Top level of the ordered list table engine: controller plus datapath.
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------
//  item in   start, busy (accept when  i_item  (operation, position,
//            start && !busy)                    value_real, value_imag)
//  result    o_done (one-cycle strobe) o_result (status, read_real,
//                                       read_imag, found_position,
//                                       entry_count)
//
// One item at a time, all entries in one memory with registered read.
// Append, overwrite, range and full errors and unused codes finish in the
// check state; read fetches the entry and returns it from S_READ. Insert,
// delete and find walk the list entry by entry (insert shifts up, delete
// shifts down, find scans from entry 0): each moved or compared entry costs
// one memory read in S_STEP_RD and a use of the data in S_STEP_WR. busy
// drops in the result cycle, so the next item may be taken then. Synchronous
// active-low reset empties the list; the receiver cannot stall.
module ordered_list_table_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  olte_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_done,
    output olte_pkg::t_result o_result
);
    import olte_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    olte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    olte_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (dp_status),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

[hdl/olte_checker.sv]
// Port-level checker for the ordered list table engine, bound to the top level.
module olte_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input olte_pkg::t_result o_result
);
    import olte_pkg::*;

    // the engine is busy in the cycle after it accepts an item
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after accepting an item");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while engine still busy");

    a_done_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("two results in consecutive cycles");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
            (o_result.read_real == '0 && o_result.read_imag == '0 &&
             o_result.found_position == '0))
        else $error("error result carries data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |->
            (o_result.entry_count == ECNT_W'(DEPTH)))
        else $error("full status with table not full");

endmodule

bind ordered_list_table_engine olte_checker u_olte_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
